FILE: hdl/deq_pkg.sv
`default_nettype none

package deq_pkg;

    // Fixed field widths of one input item and one result item.
    localparam int VALUE_W   = 32;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 7;

    // Default ring size.
    localparam int DEFAULT_DEPTH = 64;

    // Operation codes carried by the mode field.
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ_FWD   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_BWD   = 3'd5;

    // Status codes of a result item.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // One result item as it sits in the output and holding registers.
    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic [STATUS_W-1:0]  status;
        logic [ENTRIES_W-1:0] entries;
        logic                 last;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/deq_ram.sv
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; read data holds while
    // no read is enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/double_ended_queue_unit.sv
`default_nettype none

// Bounded double-ended queue of signed 32-bit values kept as a ring of DEPTH
// entries in one synchronous RAM. Each input item pushes at the front or back,
// pops from the front or back, or reads the whole queue out in either
// direction. A push, a full push, and a pop or read-out of an empty queue give
// one result each; a new item may follow in the next cycle while that result
// still waits on the output. A pop stalls input until its registered RAM read
// reaches the output register. A read-out of N entries gives N results and
// stalls input until the last has left; one read is issued per cycle unless
// the output stalls, and each entry leaves once the output register is free.
// Unused mode codes are accepted and give no result. The RAM needs no clearing
// after reset, since only entries that a push wrote are ever read.
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic        [MODE_W-1:0]    i_mode,
    input  wire logic signed [VALUE_W-1:0]   i_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic signed      [VALUE_W-1:0]   o_value_res,
    output logic             [STATUS_W-1:0]  o_status,
    output logic             [ENTRIES_W-1:0] o_entries,
    output logic                             o_last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HOLD = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    localparam logic [IW-1:0] LAST_POS = IW'(DEPTH - 1);

    logic [1:0]    r_state, n_state;
    logic [IW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;
    t_result       r_pend, n_pend;

    // Read-out sequencing.
    logic [IW-1:0] r_addr, n_addr;
    logic [CW-1:0] r_left, n_left;
    logic          r_bwd, n_bwd;
    logic          r_rd_valid, n_rd_valid;
    logic          r_rd_last, n_rd_last;

    // RAM port signals.
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic                ram_re;
    logic [IW-1:0]       ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;

    logic          accept;
    logic          out_free;
    logic          is_full;
    logic          is_empty;
    logic [SW-1:0] back_sum;
    logic [IW-1:0] front_dec;
    logic [IW-1:0] front_inc;
    logic [IW-1:0] back_push_pos;
    logic [IW-1:0] back_pop_pos;
    logic [CW-1:0] count_inc;
    logic [CW-1:0] count_dec;
    logic          rd_move;
    logic          rd_issue;
    t_result       imm_res;
    logic          imm_load;

    // Folds a sum of two ring positions back into the ring.
    function automatic logic [IW-1:0] ring_wrap(input logic [SW-1:0] s);
        logic [SW-1:0] w;
        begin
            w = (s >= SW'(DEPTH)) ? (s - SW'(DEPTH)) : s;
            return w[IW-1:0];
        end
    endfunction

    deq_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_value),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Handshake and ring position arithmetic.
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign is_full    = (r_count == CW'(DEPTH));
    assign is_empty   = (r_count == '0);
    assign back_sum   = SW'(r_front) + SW'(r_count);
    assign front_dec  = (r_front == '0) ? LAST_POS : (r_front - 1'b1);
    assign front_inc  = (r_front == LAST_POS) ? '0 : (r_front + 1'b1);
    assign back_push_pos = ring_wrap(back_sum);
    assign back_pop_pos  = ring_wrap(back_sum - 1'b1);
    assign count_inc  = r_count + 1'b1;
    assign count_dec  = r_count - 1'b1;

    // Read-out flow: an entry leaves the RAM read register when the output
    // is free, and the next read is issued only into an emptied register.
    assign rd_move  = (r_state == S_READ) && r_rd_valid && out_free;
    assign rd_issue = (r_state == S_READ) && (r_left != '0) && (!r_rd_valid || rd_move);

    // Main control: decode in idle, then finish pops, read-outs and held
    // results.
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_pend      = r_pend;
        n_addr      = r_addr;
        n_left      = r_left;
        n_bwd       = r_bwd;
        n_rd_valid  = r_rd_valid;
        n_rd_last   = r_rd_last;
        ram_we      = 1'b0;
        ram_waddr   = back_push_pos;
        ram_re      = 1'b0;
        ram_raddr   = r_front;
        imm_load    = 1'b0;
        imm_res     = '{value: '0, status: STATUS_OK,
                        entries: ENTRIES_W'(r_count), last: 1'b1};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                            imm_load = 1'b1;
                            if (is_full) begin
                                imm_res.status = STATUS_FULL;
                            end else begin
                                ram_we          = 1'b1;
                                n_count         = count_inc;
                                imm_res.entries = ENTRIES_W'(count_inc);
                                if (i_mode == MODE_PUSH_FRONT) begin
                                    ram_waddr = front_dec;
                                    n_front   = front_dec;
                                end
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_BACK: begin
                            if (is_empty) begin
                                imm_load       = 1'b1;
                                imm_res.status = STATUS_EMPTY;
                            end else begin
                                ram_re  = 1'b1;
                                n_count = count_dec;
                                n_pend  = '{value: '0, status: STATUS_OK,
                                            entries: ENTRIES_W'(count_dec), last: 1'b1};
                                n_state = S_POP;
                                if (i_mode == MODE_POP_FRONT) begin
                                    n_front = front_inc;
                                end else begin
                                    ram_raddr = back_pop_pos;
                                end
                            end
                        end
                        MODE_READ_FWD, MODE_READ_BWD: begin
                            if (is_empty) begin
                                imm_load       = 1'b1;
                                imm_res.status = STATUS_EMPTY;
                            end else begin
                                n_bwd      = (i_mode == MODE_READ_BWD);
                                n_addr     = (i_mode == MODE_READ_BWD) ? back_pop_pos : r_front;
                                n_left     = r_count;
                                n_rd_valid = 1'b0;
                                n_state    = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase

                    // A ready result goes straight out or waits in the holding
                    // register.
                    if (imm_load) begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out       = imm_res;
                        end else begin
                            n_pend  = imm_res;
                            n_state = S_HOLD;
                        end
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    n_state     = S_IDLE;
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    n_out.value = ram_rdata;
                    n_state     = S_IDLE;
                end
            end
            S_READ: begin
                if (rd_move) begin
                    n_out_valid = 1'b1;
                    n_out       = '{value: ram_rdata, status: STATUS_OK,
                                    entries: ENTRIES_W'(r_count), last: r_rd_last};
                    n_rd_valid  = 1'b0;
                    if (r_rd_last) begin
                        n_state = S_IDLE;
                    end
                end
                if (rd_issue) begin
                    ram_re     = 1'b1;
                    ram_raddr  = r_addr;
                    n_left     = r_left - 1'b1;
                    n_rd_valid = 1'b1;
                    n_rd_last  = (r_left == CW'(1));
                    if (r_bwd) begin
                        n_addr = (r_addr == '0) ? LAST_POS : (r_addr - 1'b1);
                    end else begin
                        n_addr = (r_addr == LAST_POS) ? '0 : (r_addr + 1'b1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_rd_valid  <= n_rd_valid;
        end
    end

    // Payload and sequencing registers.
    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_pend    <= n_pend;
        r_addr    <= n_addr;
        r_left    <= n_left;
        r_bwd     <= n_bwd;
        r_rd_last <= n_rd_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_value_res = r_out.value;
    assign o_status    = r_out.status;
    assign o_entries   = r_out.entries;
    assign o_last      = r_out.last;

    // The fill count never passes the ring size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds ring size");

    // The front position always lies inside the ring.
    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= LAST_POS)
        else $error("front position outside ring");

    // A push into a queue that is not full adds exactly one entry.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_full && (i_mode == MODE_PUSH_FRONT || i_mode == MODE_PUSH_BACK))
        |=> (r_count == $past(count_inc)))
        else $error("push did not add one entry");

    // A read-out leaves no entry behind in the RAM read register.
    a_read_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_rd_valid)
        else $error("read-out left an entry pending");

    // An entry moved out during a read-out shows on the output next cycle.
    a_read_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_move |=> o_out_valid)
        else $error("read-out entry lost");

endmodule

`default_nettype wire

FILE: tb/deq_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the deque, keeps its own copy of the ring,
// and compares every result item with the oldest predicted one.
module deq_result_checker
    import deq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic        [MODE_W-1:0]    i_mode,
    input  logic        [VALUE_W-1:0]   i_value,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic        [VALUE_W-1:0]   i_value_res,
    input  logic        [STATUS_W-1:0]  i_status,
    input  logic        [ENTRIES_W-1:0] i_entries,
    input  logic                        i_last,
    output int                          o_mismatch_count,
    output int                          o_pending_count
);

    // Shadow copy of the ring and its bookkeeping.
    logic [VALUE_W-1:0] ring_store [DEPTH];
    int unsigned        front_pos;
    int unsigned        held;

    // Results predicted but not yet seen on the output.
    t_result            pending_results [$];
    t_result            oldest;
    int                 mismatch_count = 0;

    // Queues one predicted result; the entry count reflects the state after the item.
    task automatic queue_result(input logic [VALUE_W-1:0] data,
                                input logic [STATUS_W-1:0] code, input logic fin);
        t_result r;
        r.value   = data;
        r.status  = code;
        r.entries = held[ENTRIES_W-1:0];
        r.last    = fin;
        pending_results.push_back(r);
    endtask

    // Applies one accepted item to the shadow ring and predicts its results.
    task automatic apply_operation(input logic [MODE_W-1:0] op,
                                   input logic [VALUE_W-1:0] data);
        int unsigned pos;
        int unsigned off;
        case (op)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    queue_result('0, STATUS_FULL, 1'b1);
                end else begin
                    if (op == MODE_PUSH_FRONT) begin
                        front_pos = (front_pos + DEPTH - 1) % DEPTH;
                        ring_store[front_pos] = data;
                    end else begin
                        ring_store[(front_pos + held) % DEPTH] = data;
                    end
                    held = held + 1;
                    queue_result('0, STATUS_OK, 1'b1);
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
                if (held == 0) begin
                    queue_result('0, STATUS_EMPTY, 1'b1);
                end else begin
                    if (op == MODE_POP_FRONT) begin
                        pos = front_pos;
                        front_pos = (front_pos + 1) % DEPTH;
                    end else begin
                        pos = (front_pos + held - 1) % DEPTH;
                    end
                    held = held - 1;
                    queue_result(ring_store[pos], STATUS_OK, 1'b1);
                end
            end
            MODE_READ_FWD, MODE_READ_BWD: begin
                if (held == 0) begin
                    queue_result('0, STATUS_EMPTY, 1'b1);
                end else begin
                    for (int unsigned k = 0; k < held; k++) begin
                        off = (op == MODE_READ_FWD) ? k : held - 1 - k;
                        queue_result(ring_store[(front_pos + off) % DEPTH], STATUS_OK,
                                     k + 1 == held);
                    end
                end
            end
            default: begin
                // Unused codes leave the ring alone and give no result.
            end
        endcase
    endtask

    // Reports one field that differs from its prediction.
    task automatic check_field(input string label, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, label, want, got);
            mismatch_count = mismatch_count + 1;
        end
    endtask

    // Both channels are sampled on the same edge the handshake completes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_pos = 0;
            held      = 0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual value 0x%0h",
                             $time, i_value_res);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("value_res", oldest.value, i_value_res);
                    check_field("status", VALUE_W'(oldest.status), VALUE_W'(i_status));
                    check_field("entries", VALUE_W'(oldest.entries), VALUE_W'(i_entries));
                    check_field("last", VALUE_W'(oldest.last), VALUE_W'(i_last));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_operation(i_mode, i_value);
            end
        end
        o_mismatch_count <= mismatch_count;
        o_pending_count  <= pending_results.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import deq_pkg::*;
();

    localparam int DEPTH        = DEFAULT_DEPTH;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int FILL_ITEMS   = DEPTH + 6;

    // Mode codes the block ignores.
    localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [MODE_W-1:0]    mode      = MODE_PUSH_FRONT;
    logic [VALUE_W-1:0]   value     = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [VALUE_W-1:0]   value_res;
    logic [STATUS_W-1:0]  status;
    logic [ENTRIES_W-1:0] entries;
    logic                 res_last;

    logic                 calm      = 1'b0;
    logic                 hold_req  = 1'b0;
    int                   hold_left = 0;
    int                   cycle_count = 0;
    int                   mismatch_count;
    int                   pending_count;

    double_ended_queue_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_mode     (mode),
        .i_value    (value),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_value_res(value_res),
        .o_status   (status),
        .o_entries  (entries),
        .o_last     (res_last)
    );

    deq_result_checker #(
        .DEPTH(DEPTH)
    ) u_result_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_mode          (mode),
        .i_value         (value),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_value_res     (value_res),
        .i_status        (status),
        .i_entries       (entries),
        .i_last          (res_last),
        .o_mismatch_count(mismatch_count),
        .o_pending_count (pending_count)
    );

    // Clock with a period of 8 ns.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(posedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(99) < 12);
        end
    end

    // Offers one item, with random idle cycles ahead of it, and waits until it is taken.
    task automatic send_item(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] data);
        while (!calm && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        value    <= data;
        do @(posedge clk); while (in_stall);
    endtask

    // Random value with the extremes mixed in.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Random operation, leaning toward pushes so the ring reaches deeper fills.
    function automatic logic [MODE_W-1:0] pick_mode();
        int r;
        r = $urandom_range(99);
        if (r < 24) return MODE_PUSH_FRONT;
        if (r < 48) return MODE_PUSH_BACK;
        if (r < 66) return MODE_POP_FRONT;
        if (r < 84) return MODE_POP_BACK;
        if (r < 91) return MODE_READ_FWD;
        if (r < 97) return MODE_READ_BWD;
        return $urandom_range(1) ? MODE_UNUSED_6 : MODE_UNUSED_7;
    endfunction

    // Random mix; ignored codes do not count toward the total.
    task automatic run_mix(input int total);
        int                sent;
        logic [MODE_W-1:0] op;
        sent = 0;
        while (sent < total) begin
            op = pick_mode();
            send_item(op, pick_value());
            if (op <= MODE_READ_BWD) begin
                sent = sent + 1;
            end
        end
    endtask

    // Enough pushes to fill the ring from any level, plus a few that hit it full.
    task automatic fill_ring();
        for (int k = 0; k < FILL_ITEMS; k++) begin
            send_item($urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, pick_value());
        end
    endtask

    // Enough pops to empty the ring from any level, plus a few on empty.
    task automatic drain_ring();
        for (int k = 0; k < FILL_ITEMS; k++) begin
            send_item($urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK, $urandom);
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue, ignored codes, extreme values, both read directions,
        // removal of the only entry, and a push into an empty queue.
        send_item(MODE_POP_FRONT, $urandom);
        send_item(MODE_POP_BACK, $urandom);
        send_item(MODE_READ_FWD, $urandom);
        send_item(MODE_READ_BWD, $urandom);
        send_item(MODE_UNUSED_6, $urandom);
        send_item(MODE_UNUSED_7, $urandom);
        send_item(MODE_PUSH_FRONT, 32'h8000_0000);
        send_item(MODE_PUSH_BACK, 32'h7FFF_FFFF);
        send_item(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
        send_item(MODE_PUSH_BACK, 32'h0000_0000);
        send_item(MODE_PUSH_FRONT, 32'h5555_5555);
        send_item(MODE_PUSH_BACK, 32'hAAAA_AAAA);
        send_item(MODE_READ_FWD, $urandom);
        send_item(MODE_READ_BWD, $urandom);
        send_item(MODE_POP_FRONT, $urandom);
        send_item(MODE_POP_BACK, $urandom);
        send_item(MODE_READ_FWD, $urandom);
        send_item(MODE_POP_BACK, $urandom);
        send_item(MODE_POP_FRONT, $urandom);
        send_item(MODE_POP_FRONT, $urandom);
        send_item(MODE_POP_BACK, $urandom);
        send_item(MODE_POP_BACK, $urandom);
        send_item(MODE_PUSH_BACK, 32'h0000_0001);
        send_item(MODE_POP_FRONT, $urandom);

        // Hold the result side off at the start of the fill, so the block backs up.
        hold_req <= 1'b1;
        send_item(MODE_PUSH_BACK, pick_value());
        hold_req <= 1'b0;
        fill_ring();
        send_item(MODE_READ_FWD, $urandom);
        send_item(MODE_READ_BWD, $urandom);
        drain_ring();

        // A stretch with no idling on either side, then random idling again.
        calm <= 1'b1;
        run_mix(100);
        calm <= 1'b0;
        run_mix(100);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
